// ===== hdl/dpsc_pkg.sv =====
// Shared types and constants for the dual player sync controller.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package dpsc_pkg;

    typedef enum logic [1:0] {
        PH_DETECT  = 2'd0,
        PH_IDLE    = 2'd1,
        PH_PREROLL = 2'd2,
        PH_ROLLING = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_PREROLL_TICKS    = 2'd0,
        CFG_FOUND_THRESHOLD  = 2'd1,
        CFG_BLINK_HALF_TICKS = 2'd2,
        CFG_GAP_TICKS        = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        LAMP_OFF   = 2'd0,
        LAMP_ON    = 2'd1,
        LAMP_BLINK = 2'd2
    } lamp_mode_t;

    localparam logic [7:0] PREROLL_TICKS_RST    = 8'd150;
    localparam logic [7:0] FOUND_THRESHOLD_RST  = 8'd5;
    localparam logic [3:0] BLINK_HALF_TICKS_RST = 4'd5;
    localparam logic [4:0] GAP_TICKS_RST        = 5'd20;

    localparam logic [7:0] ZERO_RUN_MAX = 8'd255;
    localparam logic [7:0] START_BYTE   = 8'h01;
    localparam logic [7:0] STOP_BYTE    = 8'h00;

    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_P = 8'h50;
    localparam logic [7:0] CHAR_R = 8'h52;

    localparam logic [2:0] PATTERN_DETECT  = 3'd1;
    localparam logic [2:0] PATTERN_IDLE    = 3'd2;
    localparam logic [2:0] PATTERN_PREROLL = 3'd3;
    localparam logic [2:0] PATTERN_ROLLING = 3'd4;

    typedef struct packed {
        logic       tick;
        logic       button_down;
        logic       rx0_valid;
        logic [7:0] rx0_byte;
        logic       rx1_valid;
        logic [7:0] rx1_byte;
    } step_word_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       led_on;
        logic       button_light_on;
        logic       status_valid;
        logic [7:0] status_char;
        logic       start_cmd;
        logic       activity0;
        logic       activity1;
    } result_word_t;

endpackage

// ===== hdl/dpsc_step_if.sv =====
// Valid/ready channel carrying one control loop pass word.
// Depends on nothing; compiled after dpsc_pkg.
`timescale 1ns / 1ps

interface dpsc_step_if;
    logic       valid;
    logic       ready;
    logic       tick;
    logic       button_down;
    logic       rx0_valid;
    logic [7:0] rx0_byte;
    logic       rx1_valid;
    logic [7:0] rx1_byte;

    modport source (
        output valid, tick, button_down, rx0_valid, rx0_byte, rx1_valid, rx1_byte,
        input  ready
    );

    modport sink (
        input  valid, tick, button_down, rx0_valid, rx0_byte, rx1_valid, rx1_byte,
        output ready
    );
endinterface

// ===== hdl/dpsc_result_if.sv =====
// Valid/ready channel carrying one result word per pass.
// Depends on nothing; compiled after dpsc_pkg.
`timescale 1ns / 1ps

interface dpsc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] phase;
    logic       led_on;
    logic       button_light_on;
    logic       status_valid;
    logic [7:0] status_char;
    logic       start_cmd;
    logic       activity0;
    logic       activity1;

    modport source (
        output valid, phase, led_on, button_light_on, status_valid, status_char,
               start_cmd, activity0, activity1,
        input  ready
    );

    modport sink (
        input  valid, phase, led_on, button_light_on, status_valid, status_char,
               start_cmd, activity0, activity1,
        output ready
    );
endinterface

// ===== hdl/dual_player_sync_controller_top.sv =====
// Dual player sync controller: detect, idle, preroll and rolling control loop.
// Depends on dpsc_pkg, dpsc_step_if and dpsc_result_if.
//
//   channel   dir   handshake     word
//   step      in    valid/ready   tick, button, two rx bytes
//   result    out   valid/ready   phase, LEDs, status char, start, activity
//   cfg       in    cfg_we        cfg_index, cfg_data (no read-back)
//
// Words pass through an input register, then one pass of flag and counter
// logic into the result register. One word is accepted every cycle unless stalled.
// The result register only stalls the input side when it is full and not taken.
// rst_n clears all state asynchronously; configuration returns to its defaults.
`timescale 1ns / 1ps

module dual_player_sync_controller_top (
    input  logic                     clk,
    input  logic                     rst_n,
    dpsc_step_if.sink                step,
    dpsc_result_if.source            result,
    input  logic                     cfg_we,
    input  dpsc_pkg::cfg_index_t     cfg_index,
    input  logic [7:0]               cfg_data
);
    import dpsc_pkg::*;

    typedef enum logic [1:0] {
        DB_WAIT    = 2'd0,
        DB_CHECK   = 2'd1,
        DB_HELD    = 2'd2,
        DB_RELEASE = 2'd3
    } db_state_t;

    logic [7:0]   preroll_ticks_reg;
    logic [7:0]   found_threshold_reg;
    logic [3:0]   blink_half_reg;
    logic [4:0]   gap_ticks_reg;

    step_word_t   step_reg;
    logic         step_valid_reg;
    result_word_t res_reg, res_next;
    logic         res_valid_reg;
    logic         advance;

    phase_t       phase_reg, phase_next;
    logic [1:0]   found_reg, found_next;
    logic [1:0]   reply_valid_reg, reply_valid_next;
    logic [1:0][7:0] last_reply_reg, last_reply_next;
    logic [1:0][7:0] zero_run_reg, zero_run_next;
    logic [2:0]   led_pattern_reg, led_pattern_next;
    logic [4:0]   led_timer_reg, led_timer_next;
    logic [2:0]   led_count_reg, led_count_next;
    logic         led_level_reg, led_level_next;
    lamp_mode_t   lamp_mode_reg, lamp_mode_next;
    logic [4:0]   lamp_timer_reg, lamp_timer_next;
    logic         lamp_level_reg, lamp_level_next;
    db_state_t    db_reg, db_next;
    logic [7:0]   delay_reg, delay_next;
    logic [1:0]   activity_reg, activity_next;

    logic         pressed;
    logic         leave;
    logic         reply_mode;
    logic         enter;
    phase_t       enter_phase;
    logic [2:0]   enter_pattern;
    lamp_mode_t   enter_lamp;
    logic [7:0]   status;
    logic         start;
    logic [1:0]   rx_valid;
    logic [1:0][7:0] rx_byte;
    logic [1:0]   rep_start_ok;
    logic [1:0]   rep_stop_ok;
    logic [4:0]   half_w;
    logic [4:0]   full_w;

    assign advance      = step_valid_reg && (!res_valid_reg || result.ready);
    assign step.ready   = !step_valid_reg || advance;

    assign rx_valid     = {step_reg.rx1_valid, step_reg.rx0_valid};
    assign rx_byte      = {step_reg.rx1_byte, step_reg.rx0_byte};
    assign half_w       = {1'b0, blink_half_reg};
    assign full_w       = {blink_half_reg, 1'b0};

    always_comb
    begin
        phase_next       = phase_reg;
        found_next       = found_reg;
        reply_valid_next = reply_valid_reg;
        last_reply_next  = last_reply_reg;
        zero_run_next    = zero_run_reg;
        led_pattern_next = led_pattern_reg;
        led_timer_next   = led_timer_reg;
        led_count_next   = led_count_reg;
        led_level_next   = led_level_reg;
        lamp_mode_next   = lamp_mode_reg;
        lamp_timer_next  = lamp_timer_reg;
        lamp_level_next  = lamp_level_reg;
        db_next          = db_reg;
        delay_next       = delay_reg;
        activity_next    = activity_reg;
        pressed          = 1'b0;
        leave            = 1'b0;
        enter            = 1'b0;
        enter_phase      = PH_IDLE;
        enter_pattern    = PATTERN_IDLE;
        enter_lamp       = LAMP_ON;
        status           = 8'd0;
        start            = 1'b0;

        for (int i = 0; i < 2; i++)
        begin
            rep_start_ok[i] = !found_reg[i]
                              || (reply_valid_reg[i] && last_reply_reg[i] == START_BYTE);
            rep_stop_ok[i]  = !found_reg[i]
                              || (reply_valid_reg[i] && last_reply_reg[i] == STOP_BYTE);
        end

        // debounce
        if ((phase_reg == PH_DETECT && step_reg.tick) || phase_reg == PH_IDLE)
        begin
            case (db_reg)
                DB_WAIT:
                begin
                    if (step_reg.button_down)
                        db_next = DB_CHECK;
                end
                DB_CHECK:
                begin
                    if (step_reg.button_down)
                    begin
                        db_next = DB_HELD;
                        pressed = 1'b1;
                    end
                    else
                        db_next = DB_WAIT;
                end
                DB_HELD:
                begin
                    if (!step_reg.button_down)
                        db_next = DB_RELEASE;
                end
                default:
                begin
                    db_next = step_reg.button_down ? DB_HELD : DB_WAIT;
                end
            endcase
        end

        // blink pattern LED and button lamp
        if (step_reg.tick)
        begin
            if (led_count_reg < led_pattern_reg)
            begin
                if (led_timer_reg < half_w)
                begin
                    led_level_next = 1'b1;
                    led_timer_next = led_timer_reg + 5'd1;
                end
                else if (led_timer_reg < full_w)
                begin
                    led_level_next = 1'b0;
                    led_timer_next = led_timer_reg + 5'd1;
                end
                else
                begin
                    led_timer_next = 5'd0;
                    led_count_next = led_count_reg + 3'd1;
                end
            end
            else if (led_timer_reg < gap_ticks_reg)
                led_timer_next = led_timer_reg + 5'd1;
            else
            begin
                led_timer_next = 5'd0;
                led_count_next = 3'd0;
            end

            case (lamp_mode_reg)
                LAMP_OFF: lamp_level_next = 1'b0;
                LAMP_ON:  lamp_level_next = 1'b1;
                default:
                begin
                    if (lamp_timer_reg < half_w)
                    begin
                        lamp_level_next = 1'b1;
                        lamp_timer_next = lamp_timer_reg + 5'd1;
                    end
                    else if (lamp_timer_reg < full_w)
                    begin
                        lamp_level_next = 1'b0;
                        lamp_timer_next = lamp_timer_reg + 5'd1;
                    end
                    else
                        lamp_timer_next = 5'd0;
                end
            endcase
        end

        if (phase_reg == PH_DETECT)
        begin
            leave = step_reg.tick && pressed && (found_reg[0] || found_reg[1]);
            if (step_reg.tick && !leave)
                status = CHAR_D;
        end
        else if (step_reg.tick)
        begin
            case (phase_reg)
                PH_IDLE:    status = CHAR_I;
                PH_PREROLL: status = CHAR_P;
                default:    status = CHAR_R;
            endcase
            if (delay_reg != 8'd0)
                delay_next = delay_reg - 8'd1;
        end

        reply_mode = leave || phase_reg != PH_DETECT;

        // received bytes
        for (int i = 0; i < 2; i++)
        begin
            if (rx_valid[i])
            begin
                last_reply_next[i] = rx_byte[i];
                activity_next[i]   = !activity_reg[i];
                if (!reply_mode)
                begin
                    if (rx_byte[i] != 8'd0)
                        zero_run_next[i] = 8'd0;
                    else if (zero_run_reg[i] != ZERO_RUN_MAX)
                        zero_run_next[i] = zero_run_reg[i] + 8'd1;
                end
            end
            if (!reply_mode)
                found_next[i] = zero_run_next[i] > found_threshold_reg;
        end

        case (phase_reg)
            PH_DETECT:
            begin
                enter = leave || (found_next[0] && found_next[1]);
            end
            PH_IDLE:
            begin
                if (pressed)
                begin
                    enter         = 1'b1;
                    enter_phase   = PH_PREROLL;
                    enter_pattern = PATTERN_PREROLL;
                    enter_lamp    = LAMP_BLINK;
                    start         = 1'b1;
                    delay_next    = preroll_ticks_reg;
                end
            end
            PH_PREROLL:
            begin
                if (&rep_start_ok && delay_next == 8'd0)
                begin
                    enter         = 1'b1;
                    enter_phase   = PH_ROLLING;
                    enter_pattern = PATTERN_ROLLING;
                    enter_lamp    = LAMP_OFF;
                end
            end
            default:
            begin
                enter = &rep_stop_ok;
            end
        endcase

        if (enter)
        begin
            phase_next       = enter_phase;
            led_pattern_next = enter_pattern;
            lamp_mode_next   = enter_lamp;
            led_timer_next   = 5'd0;
            led_count_next   = 3'd0;
            lamp_timer_next  = 5'd0;
            reply_valid_next = 2'b00;
        end

        for (int i = 0; i < 2; i++)
        begin
            if (reply_mode && rx_valid[i])
                reply_valid_next[i] = 1'b1;
        end

        res_next.phase           = phase_next;
        res_next.led_on          = led_level_next;
        res_next.button_light_on = lamp_level_next;
        res_next.status_valid    = status != 8'd0;
        res_next.status_char     = status;
        res_next.start_cmd       = start;
        res_next.activity0       = activity_next[0];
        res_next.activity1       = activity_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preroll_ticks_reg   <= PREROLL_TICKS_RST;
            found_threshold_reg <= FOUND_THRESHOLD_RST;
            blink_half_reg      <= BLINK_HALF_TICKS_RST;
            gap_ticks_reg       <= GAP_TICKS_RST;
            step_reg            <= '0;
            step_valid_reg      <= 1'b0;
            res_reg             <= '0;
            res_valid_reg       <= 1'b0;
            phase_reg           <= PH_DETECT;
            found_reg           <= 2'b00;
            reply_valid_reg     <= 2'b00;
            last_reply_reg      <= '0;
            zero_run_reg        <= '0;
            led_pattern_reg     <= PATTERN_DETECT;
            led_timer_reg       <= 5'd0;
            led_count_reg       <= 3'd0;
            led_level_reg       <= 1'b0;
            lamp_mode_reg       <= LAMP_OFF;
            lamp_timer_reg      <= 5'd0;
            lamp_level_reg      <= 1'b0;
            db_reg              <= DB_WAIT;
            delay_reg           <= 8'd0;
            activity_reg        <= 2'b00;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PREROLL_TICKS:    preroll_ticks_reg   <= cfg_data;
                    CFG_FOUND_THRESHOLD:  found_threshold_reg <= cfg_data;
                    CFG_BLINK_HALF_TICKS: blink_half_reg      <= cfg_data[3:0];
                    default:              gap_ticks_reg       <= cfg_data[4:0];
                endcase
            end

            if (step.valid && step.ready)
            begin
                step_reg.tick        <= step.tick;
                step_reg.button_down <= step.button_down;
                step_reg.rx0_valid   <= step.rx0_valid;
                step_reg.rx0_byte    <= step.rx0_byte;
                step_reg.rx1_valid   <= step.rx1_valid;
                step_reg.rx1_byte    <= step.rx1_byte;
                step_valid_reg       <= 1'b1;
            end
            else if (advance)
                step_valid_reg <= 1'b0;

            if (advance)
            begin
                res_reg         <= res_next;
                res_valid_reg   <= 1'b1;
                phase_reg       <= phase_next;
                found_reg       <= found_next;
                reply_valid_reg <= reply_valid_next;
                last_reply_reg  <= last_reply_next;
                zero_run_reg    <= zero_run_next;
                led_pattern_reg <= led_pattern_next;
                led_timer_reg   <= led_timer_next;
                led_count_reg   <= led_count_next;
                led_level_reg   <= led_level_next;
                lamp_mode_reg   <= lamp_mode_next;
                lamp_timer_reg  <= lamp_timer_next;
                lamp_level_reg  <= lamp_level_next;
                db_reg          <= db_next;
                delay_reg       <= delay_next;
                activity_reg    <= activity_next;
            end
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.phase           = res_reg.phase;
    assign result.led_on          = res_reg.led_on;
    assign result.button_light_on = res_reg.button_light_on;
    assign result.status_valid    = res_reg.status_valid;
    assign result.status_char     = res_reg.status_char;
    assign result.start_cmd       = res_reg.start_cmd;
    assign result.activity0       = res_reg.activity0;
    assign result.activity1       = res_reg.activity1;

    a_start_in_preroll: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.start_cmd |-> result.phase == PH_PREROLL)
        else $error("start command outside preroll");

    a_status_coded: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.status_valid |-> result.status_char == 8'd0)
        else $error("status char without status valid");

    a_phase_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_next != phase_reg
        |=> led_timer_reg == 5'd0 && led_count_reg == 3'd0 && lamp_timer_reg == 5'd0)
        else $error("phase change left blink timers running");

    a_rolling_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ROLLING |-> delay_reg == 8'd0)
        else $error("preroll delay pending while rolling");

endmodule

// ===== test/dual_player_sync_controller_top_test.sv =====
// Self-checking test of dual_player_sync_controller_top: directed detect passes, a press exit,
// then random idle/preroll/rolling traffic under several register settings and stall mixes.
// Depends on dpsc_pkg, dpsc_step_if, dpsc_result_if and the top level in hdl/.
`timescale 1ns / 1ps

import dpsc_pkg::*;

typedef enum bit [1:0] {
    BTN_UP      = 2'd0,
    BTN_ARMED   = 2'd1,
    BTN_HELD    = 2'd2,
    BTN_LETGO   = 2'd3
} button_state_t;

class player_sync_state;
    logic [7:0]    preroll_ticks;
    logic [7:0]    found_threshold;
    logic [3:0]    blink_half;
    logic [4:0]    gap_ticks;
    phase_t        phase;
    bit            found [2];
    bit            reply_ok [2];
    logic [7:0]    last_reply [2];
    logic [7:0]    zero_run [2];
    logic [2:0]    led_pattern;
    logic [4:0]    led_timer;
    logic [2:0]    led_count;
    bit            led_level;
    lamp_mode_t    lamp_mode;
    logic [4:0]    lamp_timer;
    bit            lamp_level;
    button_state_t button;
    logic [7:0]    delay_left;
    bit            activity [2];
    result_word_t  pending_reports [$];
    int            bad_reports;

    function new();
        preroll_ticks   = PREROLL_TICKS_RST;
        found_threshold = FOUND_THRESHOLD_RST;
        blink_half      = BLINK_HALF_TICKS_RST;
        gap_ticks       = GAP_TICKS_RST;
        phase           = PH_DETECT;
        foreach (found[i])
        begin
            found[i]      = 1'b0;
            reply_ok[i]   = 1'b0;
            last_reply[i] = 8'h00;
            zero_run[i]   = 8'h00;
            activity[i]   = 1'b0;
        end
        led_pattern = PATTERN_DETECT;
        led_timer   = '0;
        led_count   = '0;
        led_level   = 1'b0;
        lamp_mode   = LAMP_OFF;
        lamp_timer  = '0;
        lamp_level  = 1'b0;
        button      = BTN_UP;
        delay_left  = 8'h00;
        bad_reports = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [7:0] value);
        case (idx)
            CFG_PREROLL_TICKS:    preroll_ticks = value;
            CFG_FOUND_THRESHOLD:  found_threshold = value;
            CFG_BLINK_HALF_TICKS: blink_half = value[3:0];
            CFG_GAP_TICKS:        gap_ticks = value[4:0];
        endcase
    endfunction

    function void enter(phase_t p, logic [2:0] pattern, lamp_mode_t lamp);
        phase       = p;
        led_pattern = pattern;
        lamp_mode   = lamp;
        led_timer   = '0;
        led_count   = '0;
        lamp_timer  = '0;
        reply_ok[0] = 1'b0;
        reply_ok[1] = 1'b0;
    endfunction

    function void blink_led();
        int h;
        h = blink_half;
        if (led_count < led_pattern)
        begin
            if (led_timer < h)
            begin
                led_level = 1'b1;
                led_timer++;
            end
            else if (led_timer < 2 * h)
            begin
                led_level = 1'b0;
                led_timer++;
            end
            else
            begin
                led_timer = '0;
                led_count++;
            end
        end
        else if (led_timer < gap_ticks)
            led_timer++;
        else
        begin
            led_timer = '0;
            led_count = '0;
        end
    endfunction

    function void blink_lamp();
        int h;
        h = blink_half;
        case (lamp_mode)
            LAMP_OFF: lamp_level = 1'b0;
            LAMP_ON:  lamp_level = 1'b1;
            default:
            begin
                if (lamp_timer < h)
                begin
                    lamp_level = 1'b1;
                    lamp_timer++;
                end
                else if (lamp_timer < 2 * h)
                begin
                    lamp_level = 1'b0;
                    lamp_timer++;
                end
                else
                    lamp_timer = '0;
            end
        endcase
    endfunction

    function bit debounce_press(bit down);
        case (button)
            BTN_UP:
                if (down)
                    button = BTN_ARMED;
            BTN_ARMED:
            begin
                if (down)
                begin
                    button = BTN_HELD;
                    return 1'b1;
                end
                button = BTN_UP;
            end
            BTN_HELD:
                if (!down)
                    button = BTN_LETGO;
            default:
                button = down ? BTN_HELD : BTN_UP;
        endcase
        return 1'b0;
    endfunction

    function bit all_report(logic [7:0] code);
        for (int i = 0; i < 2; i++)
            if (found[i] && !(reply_ok[i] && last_reply[i] == code))
                return 1'b0;
        return 1'b1;
    endfunction

    function void take_reply(int i, logic [7:0] b);
        last_reply[i] = b;
        reply_ok[i]   = 1'b1;
        activity[i]   = ~activity[i];
    endfunction

    function result_word_t run_pass(step_word_t w);
        bit           rv [2];
        logic [7:0]   rb [2];
        logic [7:0]   status;
        bit           start;
        bit           leave;
        result_word_t r;
        rv[0]  = w.rx0_valid;
        rb[0]  = w.rx0_byte;
        rv[1]  = w.rx1_valid;
        rb[1]  = w.rx1_byte;
        status = 8'h00;
        start  = 1'b0;
        leave  = 1'b0;
        if (phase == PH_DETECT)
        begin
            if (w.tick)
            begin
                blink_led();
                blink_lamp();
                if (debounce_press(w.button_down) && (found[0] || found[1]))
                    leave = 1'b1;
                else
                    status = CHAR_D;
            end
            if (leave)
            begin
                enter(PH_IDLE, PATTERN_IDLE, LAMP_ON);
                for (int i = 0; i < 2; i++)
                    if (rv[i])
                        take_reply(i, rb[i]);
            end
            else
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (rv[i])
                    begin
                        last_reply[i] = rb[i];
                        activity[i]   = ~activity[i];
                        if (rb[i] == 8'h00)
                        begin
                            if (zero_run[i] != ZERO_RUN_MAX)
                                zero_run[i]++;
                        end
                        else
                            zero_run[i] = 8'h00;
                    end
                    found[i] = zero_run[i] > found_threshold;
                end
                if (found[0] && found[1])
                    enter(PH_IDLE, PATTERN_IDLE, LAMP_ON);
            end
        end
        else
        begin
            if (w.tick)
            begin
                blink_led();
                blink_lamp();
                case (phase)
                    PH_IDLE:    status = CHAR_I;
                    PH_PREROLL: status = CHAR_P;
                    default:    status = CHAR_R;
                endcase
                if (delay_left != 8'h00)
                    delay_left--;
            end
            case (phase)
                PH_IDLE:
                    if (debounce_press(w.button_down))
                    begin
                        enter(PH_PREROLL, PATTERN_PREROLL, LAMP_BLINK);
                        start      = 1'b1;
                        delay_left = preroll_ticks;
                    end
                PH_PREROLL:
                    if (all_report(START_BYTE) && delay_left == 8'h00)
                        enter(PH_ROLLING, PATTERN_ROLLING, LAMP_OFF);
                default:
                    if (all_report(STOP_BYTE))
                        enter(PH_IDLE, PATTERN_IDLE, LAMP_ON);
            endcase
            for (int i = 0; i < 2; i++)
                if (rv[i])
                    take_reply(i, rb[i]);
        end
        r.phase           = phase;
        r.led_on          = led_level;
        r.button_light_on = lamp_level;
        r.status_valid    = status != 8'h00;
        r.status_char     = status;
        r.start_cmd       = start;
        r.activity0       = activity[0];
        r.activity1       = activity[1];
        return r;
    endfunction

    function void note_pass(step_word_t w);
        pending_reports.push_back(run_pass(w));
    endfunction

    function void check_report(result_word_t got);
        result_word_t want;
        if (pending_reports.size() == 0)
        begin
            bad_reports++;
            if (bad_reports <= 10)
                $display("unexpected result word %h", got);
            return;
        end
        want = pending_reports.pop_front();
        if (got !== want)
        begin
            bad_reports++;
            if (bad_reports <= 10)
                $display({"result mismatch (expected/actual): phase %0d/%0d led %b/%b ",
                          "lamp %b/%b status %b:%h/%b:%h start %b/%b activity %b%b/%b%b"},
                         want.phase, got.phase, want.led_on, got.led_on,
                         want.button_light_on, got.button_light_on,
                         want.status_valid, want.status_char, got.status_valid, got.status_char,
                         want.start_cmd, got.start_cmd, want.activity0, want.activity1,
                         got.activity0, got.activity1);
        end
    endfunction
endclass

module dual_player_sync_controller_top_test;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 150000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    cfg_index_t cfg_index;
    logic [7:0] cfg_data;

    int               passes_sent;
    int               cycle_count = 0;
    int               press_left;
    bit               hold_zero0;
    player_sync_state ctrl_state;

    dpsc_step_if   step_ch ();
    dpsc_result_if result_ch ();

    dual_player_sync_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int sender_gap_pct();
        if (passes_sent < 300)
            return 6;
        else if (passes_sent < 600)
            return 86;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (passes_sent < 300)
            return 86;
        else if (passes_sent < 600)
            return 6;
        return 0;
    endfunction

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());

    always @(posedge clk)
        if (rst_n && result_ch.valid && result_ch.ready)
            ctrl_state.check_report(result_word_t'({result_ch.phase, result_ch.led_on,
                result_ch.button_light_on, result_ch.status_valid, result_ch.status_char,
                result_ch.start_cmd, result_ch.activity0, result_ch.activity1}));

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** dual_player_sync_controller_top: FAILED **");
            $finish;
        end
    end

    function automatic step_word_t pass_of(bit t, bit d, bit v0, logic [7:0] b0,
                                           bit v1, logic [7:0] b1);
        return {t, d, v0, b0, v1, b1};
    endfunction

    // Bias bytes toward what moves the current phase along.
    function automatic step_word_t random_pass(int tick_pct);
        step_word_t w;
        bit         v [2];
        logic [7:0] b [2];
        int         pick;
        w.tick = ($urandom_range(99) < tick_pct);
        if (press_left > 0)
        begin
            w.button_down = 1'b1;
            press_left--;
        end
        else if ($urandom_range(99) < 8)
        begin
            w.button_down = 1'b1;
            press_left = $urandom_range(4);
        end
        else
            w.button_down = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            v[i] = ($urandom_range(99) < 60);
            pick = $urandom_range(99);
            case (ctrl_state.phase)
                PH_DETECT:
                    b[i] = (pick < (i == 0 ? 90 : 30)) ? STOP_BYTE : 8'($urandom);
                PH_PREROLL:
                    b[i] = (pick < 75) ? START_BYTE : 8'($urandom);
                PH_ROLLING:
                    b[i] = (pick < 60) ? STOP_BYTE : (pick < 70) ? START_BYTE : 8'($urandom);
                default:
                    b[i] = (pick < 25) ? STOP_BYTE : 8'($urandom);
            endcase
        end
        if (hold_zero0)
        begin
            v[0] = 1'b1;
            b[0] = STOP_BYTE;
        end
        w.rx0_valid = v[0];
        w.rx0_byte  = b[0];
        w.rx1_valid = v[1];
        w.rx1_byte  = b[1];
        return w;
    endfunction

    task automatic send_pass(step_word_t w);
        while ($urandom_range(99) < sender_gap_pct())
        begin
            step_ch.valid <= 1'b0;
            @(negedge clk);
        end
        step_ch.valid       <= 1'b1;
        step_ch.tick        <= w.tick;
        step_ch.button_down <= w.button_down;
        step_ch.rx0_valid   <= w.rx0_valid;
        step_ch.rx0_byte    <= w.rx0_byte;
        step_ch.rx1_valid   <= w.rx1_valid;
        step_ch.rx1_byte    <= w.rx1_byte;
        @(posedge clk);
        while (!step_ch.ready)
            @(posedge clk);
        ctrl_state.note_pass(w);
        passes_sent++;
        @(negedge clk);
    endtask

    task automatic drive_random(int count, int tick_pct);
        repeat (count)
            send_pass(random_pass(tick_pct));
    endtask

    // Hold the sender until every word in flight has come back.
    task automatic drain_results();
        step_ch.valid <= 1'b0;
        while (ctrl_state.pending_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        ctrl_state.set_reg(idx, value);
    endtask

    task automatic apply_settings(logic [7:0] preroll, logic [7:0] half, logic [7:0] gap);
        drain_results();
        write_reg(CFG_PREROLL_TICKS, preroll);
        write_reg(CFG_BLINK_HALF_TICKS, half);
        write_reg(CFG_GAP_TICKS, gap);
    endtask

    initial
    begin
        ctrl_state            = new();
        passes_sent           = 0;
        press_left            = 0;
        hold_zero0            = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_PREROLL_TICKS;
        cfg_data              = 8'h00;
        result_ch.ready       = 1'b0;
        step_ch.valid         = 1'b0;
        step_ch.tick          = 1'b0;
        step_ch.button_down   = 1'b0;
        step_ch.rx0_valid     = 1'b0;
        step_ch.rx0_byte      = 8'h00;
        step_ch.rx1_valid     = 1'b0;
        step_ch.rx1_byte      = 8'h00;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Detect with no player ever found and zero-length blinks.
        write_reg(CFG_FOUND_THRESHOLD, 8'd255);
        apply_settings(8'd255, 8'd0, 8'd0);
        send_pass(pass_of(0, 0, 0, 8'h00, 0, 8'h00));
        send_pass(pass_of(1, 0, 1, 8'hFF, 1, 8'h00));
        send_pass(pass_of(1, 1, 1, 8'h00, 1, 8'hFF));
        send_pass(pass_of(1, 1, 0, 8'h00, 1, 8'h00));
        send_pass(pass_of(0, 1, 1, 8'h00, 0, 8'h00));
        send_pass(pass_of(1, 0, 1, 8'h55, 1, 8'hAA));
        send_pass(pass_of(1, 1, 1, 8'hAA, 1, 8'h55));
        send_pass(pass_of(0, 0, 1, 8'h00, 1, 8'h00));
        send_pass(pass_of(1, 0, 0, 8'hFF, 0, 8'hFF));
        send_pass(pass_of(1, 1, 1, 8'h00, 1, 8'h00));
        send_pass(pass_of(1, 1, 1, 8'h00, 1, 8'h00));
        send_pass(pass_of(0, 0, 1, 8'h01, 1, 8'h80));
        drive_random(60, 35);

        // Saturate player zero's zero run.
        hold_zero0 = 1'b1;
        drive_random(260, 35);
        hold_zero0 = 1'b0;

        // Find player zero only, then leave detect on a press.
        drain_results();
        write_reg(CFG_FOUND_THRESHOLD, 8'd254);
        apply_settings(8'd255, 8'd15, 8'd31);
        send_pass(pass_of(1, 0, 1, STOP_BYTE, 1, 8'h7F));
        send_pass(pass_of(1, 0, 1, STOP_BYTE, 0, 8'h00));
        send_pass(pass_of(1, 1, 1, STOP_BYTE, 0, 8'h00));
        send_pass(pass_of(1, 1, 1, START_BYTE, 1, STOP_BYTE));

        drain_results();
        write_reg(CFG_FOUND_THRESHOLD, 8'd0);
        apply_settings(8'd0, 8'd1, 8'd3);
        drive_random(150, 35);
        apply_settings(8'd7, 8'd0, 8'd31);
        drive_random(120, 40);
        apply_settings(8'd255, 8'd15, 8'd0);
        drive_random(150, 90);

        drain_results();
        repeat (8) @(posedge clk);
        if (ctrl_state.bad_reports == 0 && ctrl_state.pending_reports.size() == 0)
            $display("** dual_player_sync_controller_top: PASSED **");
        else
            $display("** dual_player_sync_controller_top: FAILED **");
        $finish;
    end

endmodule
